// ----- design/stc_pkg.sv -----
// Shared types and constants for the 3x3 stencil filter.
// No dependencies; imported by every module of the block.
package stc_pkg;

    // Field widths
    localparam int PIX_W   = 8;
    localparam int X_W     = 10;
    localparam int Y_W     = 16;
    localparam int CFG_W   = 16;
    localparam int CADDR_W = 2;
    localparam int IMG_W_W = 11;
    localparam int ACC_W   = 13;   // signed kernel accumulator

    // Register indexes on the configuration port
    localparam logic [CADDR_W-1:0] CFG_FILTER_MODE  = 2'd0;
    localparam logic [CADDR_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CADDR_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

    // Filter modes
    localparam logic MODE_SHARPEN = 1'b0;
    localparam logic MODE_SOBEL   = 1'b1;

    // Reset values of the registers
    localparam logic [IMG_W_W-1:0] IMG_W_RESET = 11'd256;
    localparam logic [Y_W-1:0]     IMG_H_RESET = 16'd256;

    // 3x3 window, element 0 top left, 4 centre, 8 bottom right
    typedef logic [8:0][PIX_W-1:0] win_t;

    // Line buffer port enables
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } lb_en_t;

endpackage

// ----- design/stc_line_buf.sv -----
// Two-row line buffer: one entry per column holds the previous row (low byte)
// and the row before it (high byte). Depends on stc_pkg.
module stc_line_buf
    import stc_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic                         clk,
    input  lb_en_t                       en,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
    input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
    input  logic [2*PIX_W-1:0]           wr_data,
    output logic [2*PIX_W-1:0]           rd_data
);

    logic [2*PIX_W-1:0] mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (en.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, with the same-cycle write passed straight through
    always_ff @(posedge clk)
    begin
        if (en.rd_en)
        begin
            if (en.wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/stc_kernel.sv -----
// Combinational 3x3 kernel: sharpen or Sobel sum, clamped to 0..255.
// Depends on stc_pkg.
module stc_kernel
    import stc_pkg::*;
(
    input  logic             mode,
    input  win_t             win,
    output logic [PIX_W-1:0] value
);

    logic signed [ACC_W-1:0] p [9];
    logic signed [ACC_W-1:0] ring;
    logic signed [ACC_W-1:0] sharp;
    logic signed [ACC_W-1:0] gx;
    logic signed [ACC_W-1:0] gy;
    logic signed [ACC_W-1:0] sob;
    logic signed [ACC_W-1:0] half;

    // Widen the window to signed
    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            p[i] = signed'({{(ACC_W-PIX_W){1'b0}}, win[i]});
        end
    end

    // Sharpen: 9 * centre minus the ring
    assign ring  = p[0] + p[1] + p[2] + p[3] + p[5] + p[6] + p[7] + p[8];
    assign sharp = (p[4] <<< 3) + p[4] - ring;

    // Sobel: both gradients, halved with floor
    assign gy   = (p[6] + (p[7] <<< 1) + p[8]) - (p[0] + (p[1] <<< 1) + p[2]);
    assign gx   = (p[2] + (p[5] <<< 1) + p[8]) - (p[0] + (p[3] <<< 1) + p[6]);
    assign sob  = gx + gy;
    assign half = sob >>> 1;

    // Mode select and clamp
    always_comb
    begin
        value = '0;
        unique case (mode)
            MODE_SHARPEN:
            begin
                if (sharp < 0)
                    value = '0;
                else if (sharp > 255)
                    value = '1;
                else
                    value = sharp[PIX_W-1:0];
            end
            MODE_SOBEL:
            begin
                if (sob <= 0)
                    value = '0;
                else if (half > 255)
                    value = '1;
                else
                    value = half[PIX_W-1:0];
            end
            default:
            begin
                value = '0;
            end
        endcase
    end

endmodule

// ----- design/stencil_3x3_sharpen_sobel.sv -----
// Top level of the 3x3 stencil filter; instantiates stc_line_buf and
// stc_kernel, and takes types and constants from stc_pkg.
//
// Accepts one raster-order pixel per clock unless stalled, and gives one filtered
// value for every interior centre. The pixel and its line-buffer read are
// registered at the accepting edge; the window update and kernel then load the
// output register as the item leaves the read stage. A result held back by the
// receiver stalls the input only once an interior pixel is waiting behind it;
// border pixels produce no transaction and move on freely. The line buffer is
// not cleared after reset; the first two rows of each frame fill it before any
// result depends on it.
module stencil_3x3_sharpen_sobel
    import stc_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic               clk,
    input  logic               rst_n,
    // Configuration
    input  logic               cfg_we,
    input  logic [CADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]   cfg_wdata,
    // Pixel input
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] pixel_in
    input  logic [0:0]         s_tuser,   // [0] frame_start
    // Result output
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [39:0]        m_tdata,   // [7:0] out_value, [17:8] out_x, [33:18] out_y
    output logic               m_tlast    // frame_end
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = (CW + 1 > IMG_W_W) ? CW + 1 : IMG_W_W;
    localparam logic [WW-1:0] MAX_W_V = WW'(MAX_WIDTH);

    // Configuration registers
    logic               mode_reg;
    logic [IMG_W_W-1:0] img_w_reg;
    logic [Y_W-1:0]     img_h_reg;

    // Position counters
    logic [CW-1:0]  col_reg;
    logic [Y_W-1:0] row_reg;

    // Read stage
    logic             a_valid_reg;
    logic [PIX_W-1:0] a_pix_reg;
    logic [CW-1:0]    a_x_reg;
    logic [Y_W-1:0]   a_y_reg;
    logic             a_emit_reg;
    logic             a_last_reg;

    // Window and output register
    win_t             win_reg;
    win_t             win_next;
    logic             m_valid_reg;
    logic [PIX_W-1:0] m_value_reg;
    logic [X_W-1:0]   m_x_reg;
    logic [Y_W-1:0]   m_y_reg;
    logic             m_last_reg;

    logic             acc;
    logic             a_adv;
    logic [WW-1:0]    eff_w;
    logic [Y_W-1:0]   eff_h;
    logic [CW-1:0]    x_cur;
    logic [Y_W-1:0]   y_cur;
    logic [WW-1:0]    x_ext;
    logic [Y_W:0]     y_ext;
    logic             last_col;
    logic             last_row;
    lb_en_t           lb_en;
    logic [2*PIX_W-1:0] lb_rd;
    logic [2*PIX_W-1:0] lb_wr;
    logic [PIX_W-1:0] k_value;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_SHARPEN;
            img_w_reg <= IMG_W_RESET;
            img_h_reg <= IMG_H_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_FILTER_MODE:  mode_reg  <= cfg_wdata[0];
                CFG_IMAGE_WIDTH:  img_w_reg <= cfg_wdata[IMG_W_W-1:0];
                CFG_IMAGE_HEIGHT: img_h_reg <= cfg_wdata[Y_W-1:0];
                default:          ;
            endcase
        end
    end

    // Effective frame size
    always_comb
    begin
        eff_w = WW'(img_w_reg);
        if (eff_w < WW'(3))
            eff_w = WW'(3);
        else if (eff_w > MAX_W_V)
            eff_w = MAX_W_V;
        eff_h = (img_h_reg < Y_W'(3)) ? Y_W'(3) : img_h_reg;
    end

    // Position of the incoming pixel
    assign acc      = s_tvalid && s_tready;
    assign x_cur    = s_tuser[0] ? '0 : col_reg;
    assign y_cur    = s_tuser[0] ? '0 : row_reg;
    assign x_ext    = WW'(x_cur);
    assign y_ext    = (Y_W+1)'(y_cur);
    assign last_col = (x_ext + WW'(1)) >= eff_w;
    assign last_row = (y_ext + (Y_W+1)'(1)) >= (Y_W+1)'(eff_h);

    // Column and row counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (acc)
        begin
            if (last_col)
            begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : y_cur + Y_W'(1);
            end
            else
            begin
                col_reg <= x_cur + CW'(1);
                row_reg <= y_cur;
            end
        end
    end

    // Read stage: holds the pixel while the line buffer read completes
    assign a_adv    = a_valid_reg && (!a_emit_reg || !m_valid_reg || m_tready);
    assign s_tready = !a_valid_reg || a_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (acc)
        begin
            a_valid_reg <= 1'b1;
        end
        else if (a_adv)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            a_pix_reg  <= s_tdata;
            a_x_reg    <= x_cur;
            a_y_reg    <= y_cur;
            a_emit_reg <= (x_cur >= CW'(2)) && (y_cur >= Y_W'(2));
            a_last_reg <= (x_ext == eff_w - WW'(1)) && (y_cur == eff_h - Y_W'(1));
        end
    end

    // Line buffer: read on acceptance, write back as the item moves on
    assign lb_en.rd_en = acc;
    assign lb_en.wr_en = a_adv;
    assign lb_wr       = {lb_rd[PIX_W-1:0], a_pix_reg};

    stc_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .clk     (clk),
        .en      (lb_en),
        .rd_addr (x_cur),
        .wr_addr (a_x_reg),
        .wr_data (lb_wr),
        .rd_data (lb_rd)
    );

    // Window shifts left by one column per pixel
    always_comb
    begin
        win_next    = win_reg;
        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = lb_rd[2*PIX_W-1:PIX_W];
        win_next[3] = win_reg[4];
        win_next[4] = win_reg[5];
        win_next[5] = lb_rd[PIX_W-1:0];
        win_next[6] = win_reg[7];
        win_next[7] = win_reg[8];
        win_next[8] = a_pix_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (a_adv)
        begin
            win_reg <= win_next;
        end
    end

    stc_kernel u_kernel (
        .mode  (mode_reg),
        .win   (win_next),
        .value (k_value)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (a_adv && a_emit_reg)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_adv && a_emit_reg)
        begin
            m_value_reg <= k_value;
            m_x_reg     <= X_W'(a_x_reg - CW'(1));
            m_y_reg     <= a_y_reg - Y_W'(1);
            m_last_reg  <= a_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, m_y_reg, m_x_reg, m_value_reg};
    assign m_tlast  = m_last_reg;

endmodule

// ----- sim/stc_result_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the 3x3 stencil filter: mirrors the configuration port,
// predicts every filtered centre from accepted pixels and compares results.
// Depends on stc_pkg; instantiated beside the block by the testbench top.
module stc_result_checker
    import stc_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [CADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]   cfg_wdata,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] pixel_in
    input  logic [0:0]         s_tuser,   // [0] frame_start
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [39:0]        m_tdata,   // [7:0] out_value, [17:8] out_x, [33:18] out_y
    input  logic               m_tlast,   // frame_end
    output int                 fail_count,
    output int                 centres_due
);

    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic [X_W-1:0]   x;
        logic [Y_W-1:0]   y;
        logic             frame_end;
    } centre_t;

    centre_t            centre_q[$];
    logic [PIX_W-1:0]   row_up1 [MAX_WIDTH];   // previous row
    logic [PIX_W-1:0]   row_up2 [MAX_WIDTH];   // row before that
    logic [PIX_W-1:0]   win [9];               // 0 top left, 4 centre, 8 bottom right
    int                 col_cnt;
    int                 row_cnt;
    logic               filter_mode;
    logic [IMG_W_W-1:0] width_reg;
    logic [Y_W-1:0]     height_reg;

    function automatic int eff_width();
        if (width_reg < 3) return 3;
        if (width_reg > MAX_WIDTH) return MAX_WIDTH;
        return int'(width_reg);
    endfunction

    function automatic int eff_height();
        return (height_reg < 3) ? 3 : int'(height_reg);
    endfunction

    function automatic int px(int i);
        return int'(win[i]);
    endfunction

    function automatic logic [PIX_W-1:0] clamp_pix(int s);
        if (s < 0) return '0;
        if (s > 255) return 8'hFF;
        return s[PIX_W-1:0];
    endfunction

    // Kernel over the current window
    function automatic logic [PIX_W-1:0] kernel_value();
        int ring;
        int gx;
        int gy;
        if (filter_mode == MODE_SHARPEN)
        begin
            ring = px(0) + px(1) + px(2) + px(3) + px(5) + px(6) + px(7) + px(8);
            return clamp_pix(9 * px(4) - ring);
        end
        gy = (px(6) + 2 * px(7) + px(8)) - (px(0) + 2 * px(1) + px(2));
        gx = (px(2) + 2 * px(5) + px(8)) - (px(0) + 2 * px(3) + px(6));
        if (gx + gy <= 0) return '0;
        return clamp_pix((gx + gy) / 2);
    endfunction

    // Add a predicted centre at the tail of the queue
    task automatic append_centre(input centre_t c);
        centre_q = {centre_q, c};
    endtask

    // Advance line store, window and counters by one pixel
    task automatic take_pixel(input logic [PIX_W-1:0] pix, input logic fs);
        int               w;
        int               h;
        int               x;
        int               y;
        logic [PIX_W-1:0] up1;
        logic [PIX_W-1:0] up2;
        centre_t          c;
        w = eff_width();
        h = eff_height();
        if (fs)
        begin
            col_cnt = 0;
            row_cnt = 0;
        end
        x = col_cnt;
        y = row_cnt;
        if (x >= MAX_WIDTH) x = MAX_WIDTH - 1;

        up1 = row_up1[x];
        up2 = row_up2[x];
        row_up2[x] = up1;
        row_up1[x] = pix;

        win[0] = win[1];
        win[1] = win[2];
        win[2] = up2;
        win[3] = win[4];
        win[4] = win[5];
        win[5] = up1;
        win[6] = win[7];
        win[7] = win[8];
        win[8] = pix;

        // interior centres only
        if (x >= 2 && y >= 2)
        begin
            c.value     = kernel_value();
            c.x         = X_W'(x - 1);
            c.y         = Y_W'(y - 1);
            c.frame_end = (x == w - 1) && (y == h - 1);
            append_centre(c);
        end

        if (col_cnt + 1 >= w)
        begin
            col_cnt = 0;
            row_cnt = (row_cnt + 1 >= h) ? 0 : row_cnt + 1;
        end
        else
        begin
            col_cnt = col_cnt + 1;
        end
    endtask

    // Compare one result transaction with the oldest prediction
    task automatic check_result();
        centre_t want;
        if (centre_q.size() == 0)
        begin
            $error("unexpected result: tdata %h tlast %b", m_tdata, m_tlast);
            fail_count++;
        end
        else
        begin
            want = centre_q.pop_front();
            if (m_tdata[7:0] !== want.value)
            begin
                $error("out_value: expected %0d, actual %0d", want.value, m_tdata[7:0]);
                fail_count++;
            end
            if (m_tdata[17:8] !== want.x)
            begin
                $error("out_x: expected %0d, actual %0d", want.x, m_tdata[17:8]);
                fail_count++;
            end
            if (m_tdata[33:18] !== want.y)
            begin
                $error("out_y: expected %0d, actual %0d", want.y, m_tdata[33:18]);
                fail_count++;
            end
            if (m_tlast !== want.frame_end)
            begin
                $error("frame_end: expected %0b, actual %0b", want.frame_end, m_tlast);
                fail_count++;
            end
            if (m_tdata[39:34] !== '0)
            begin
                $error("tdata padding: expected 0, actual %h", m_tdata[39:34]);
                fail_count++;
            end
        end
    endtask

    // Monitor: configuration writes, pixel and result transactions
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_WIDTH; i++)
            begin
                row_up1[i] = '0;
                row_up2[i] = '0;
            end
            for (int i = 0; i < 9; i++)
            begin
                win[i] = '0;
            end
            col_cnt     = 0;
            row_cnt     = 0;
            filter_mode = MODE_SHARPEN;
            width_reg   = IMG_W_RESET;
            height_reg  = IMG_H_RESET;
            centre_q.delete();
            fail_count  = 0;
            centres_due <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_FILTER_MODE:  filter_mode = cfg_wdata[0];
                    CFG_IMAGE_WIDTH:  width_reg   = cfg_wdata[IMG_W_W-1:0];
                    CFG_IMAGE_HEIGHT: height_reg  = cfg_wdata[Y_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) check_result();
            if (s_tvalid && s_tready) take_pixel(s_tdata, s_tuser[0]);
            centres_due <= centre_q.size();
        end
    end

endmodule

// ----- sim/tb_stencil_3x3_sharpen_sobel.sv -----
`timescale 1ns / 100ps
// Testbench top for the 3x3 stencil filter: clock, reset, register writes,
// pixel stimulus with random idling, and the verdict.
// Depends on stc_pkg, stencil_3x3_sharpen_sobel and stc_result_checker.
module tb_stencil_3x3_sharpen_sobel;
    import stc_pkg::*;

    localparam int                 MAX_WIDTH    = 1024;
    localparam logic [CADDR_W-1:0] CFG_SPARE    = 2'd3;   // unmapped index
    localparam int                 RANDOM_ITEMS = 600;
    localparam int                 QUIET_ITEMS  = 200;    // tail with no idling
    localparam int                 DRAIN_CYCLES = 8;
    localparam int                 LONG_HOLD    = 300;
    localparam int                 WIDE_ITEMS   = 2 * MAX_WIDTH + 4;   // into the third row

    typedef enum int {PIX_UNIFORM, PIX_EXTREME, PIX_SMOOTH} pix_style_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [CADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_W-1:0]   cfg_wdata = '0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata   = '0;   // [7:0] pixel_in
    logic [0:0]         s_tuser   = '0;   // [0] frame_start
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [39:0]        m_tdata;          // [7:0] out_value, [17:8] out_x, [33:18] out_y
    logic               m_tlast;          // frame_end

    int                 fail_count;
    int                 centres_due;
    logic               idle_on   = 1'b1;
    logic               long_hold = 1'b0;
    int                 cur_w     = 256;  // effective width last written
    int                 cur_h     = 256;
    int                 pixels_sent;
    logic [7:0]         last_pix  = '0;

    stencil_3x3_sharpen_sobel #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    stc_result_checker #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .centres_due (centres_due)
    );

    // Clock
    initial
    begin
        forever #2 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #4_000_000;
        $display("[stencil_3x3_sharpen_sobel] ERROR");
        $finish;
    end

    // Receiver: random ready pattern, plus one long hold-off on request
    initial
    begin
        wait (rst_n);
        forever
        begin
            if (long_hold)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // One register write; cfg_we is dropped again before the task returns
    task automatic write_reg(input logic [CADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Stop sending and wait until every predicted centre has come out
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (centres_due != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Offer one pixel and hold it until the transaction completes
    task automatic push_pixel(input logic [7:0] pix, input logic fs);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= fs;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    function automatic logic [7:0] next_pixel(pix_style_t st);
        int v;
        case (st)
            PIX_EXTREME: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            PIX_SMOOTH:
            begin
                v = int'(last_pix) + int'($urandom_range(0, 8)) - 4;
                if (v < 0) v = 0;
                if (v > 255) v = 255;
                return v[7:0];
            end
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Stream of pixels; a stray frame start now and then
    task automatic run_items(input int n, input logic first_fs, input pix_style_t st);
        logic fs;
        for (int i = 0; i < n; i++)
        begin
            fs = (i == 0 && first_fs) || ($urandom_range(0, 399) == 0);
            last_pix = next_pixel(st);
            push_pixel(last_pix, fs);
            pixels_sent++;
        end
    endtask

    // New random setting, then one or two frames (some cut short)
    task automatic random_phase();
        int         wv;
        int         hv;
        int         ew;
        int         n;
        int         sel;
        logic       fs_needed;
        pix_style_t st;
        settle();
        fs_needed = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 3) != 0) write_reg(CFG_FILTER_MODE, CFG_W'($urandom));
        if ($urandom_range(0, 3) != 0)
        begin
            wv = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 24);
            ew = (wv < 3) ? 3 : wv;
            // a wider row needs fresh line buffers: start a new frame
            if (ew > cur_w) fs_needed = 1'b1;
            cur_w = ew;
            write_reg(CFG_IMAGE_WIDTH, {5'($urandom), 11'(wv)});
        end
        if ($urandom_range(0, 3) != 0)
        begin
            sel = $urandom_range(0, 19);
            if (sel == 0) hv = $urandom_range(0, 2);
            else if (sel == 1) hv = ($urandom_range(0, 1) != 0) ? 65535 : $urandom_range(11, 65535);
            else hv = $urandom_range(3, 10);
            cur_h = (hv < 3) ? 3 : hv;
            write_reg(CFG_IMAGE_HEIGHT, CFG_W'(hv));
        end
        if ($urandom_range(0, 5) == 0) write_reg(CFG_SPARE, CFG_W'($urandom));

        st = pix_style_t'($urandom_range(0, 2));
        for (int f = 0; f < $urandom_range(1, 2); f++)
        begin
            n = cur_w * ((cur_h > 10) ? 10 : cur_h);
            if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
            run_items(n, (f == 0) ? fs_needed : 1'b1, st);
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // lone bright centre: sharpen saturates high
        write_reg(CFG_IMAGE_WIDTH, CFG_W'(3));
        write_reg(CFG_IMAGE_HEIGHT, CFG_W'(3));
        write_reg(CFG_FILTER_MODE, CFG_W'(MODE_SHARPEN));
        cur_w = 3;
        cur_h = 3;
        for (int i = 0; i < 9; i++) push_pixel((i == 4) ? 8'hFF : 8'h00, i == 0);
        settle();

        // bright right column and bottom row: both gradients positive, result clamps high
        write_reg(CFG_FILTER_MODE, CFG_W'(MODE_SOBEL));
        for (int i = 0; i < 9; i++) push_pixel((i % 3 == 2 || i / 3 == 2) ? 8'hFF : 8'h00, i == 0);
        settle();

        // sizes below the minimum saturate to 3; spare index must be ignored;
        // inverted ramp gives a negative sum that clamps to zero
        write_reg(CFG_IMAGE_WIDTH, CFG_W'(1));
        write_reg(CFG_IMAGE_HEIGHT, CFG_W'(0));
        write_reg(CFG_SPARE, '1);
        for (int i = 0; i < 9; i++) push_pixel((i % 3 == 2 || i / 3 == 2) ? 8'h00 : 8'hFF, i == 0);
        settle();

        // widest frame: width saturates to the maximum, run into the third row
        write_reg(CFG_IMAGE_WIDTH, CFG_W'(2047));
        write_reg(CFG_IMAGE_HEIGHT, CFG_W'(2));
        write_reg(CFG_FILTER_MODE, CFG_W'($urandom_range(0, 1)));
        cur_w = MAX_WIDTH;
        cur_h = 3;
        run_items(WIDE_ITEMS, 1'b1, PIX_UNIFORM);
        settle();

        // back-pressure: receiver holds off while the sender keeps offering,
        // then the sender waits for every result mid-frame
        write_reg(CFG_IMAGE_WIDTH, CFG_W'(4));
        write_reg(CFG_IMAGE_HEIGHT, CFG_W'(8));
        cur_w = 4;
        cur_h = 8;
        long_hold = 1'b1;
        run_items(48, 1'b1, PIX_SMOOTH);
        settle();
        run_items(48, 1'b0, PIX_EXTREME);

        // random settings and frames; no idling towards the end
        pixels_sent = 0;
        while (pixels_sent < RANDOM_ITEMS)
        begin
            if (pixels_sent >= RANDOM_ITEMS - QUIET_ITEMS) idle_on = 1'b0;
            random_phase();
        end
        settle();

        if (fail_count == 0 && centres_due == 0)
        begin
            $display("[stencil_3x3_sharpen_sobel] OK");
        end
        else
        begin
            $display("[stencil_3x3_sharpen_sobel] ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/stc_pkg.sv
design/stc_line_buf.sv
design/stc_kernel.sv
design/stencil_3x3_sharpen_sobel.sv
sim/stc_result_checker.sv
sim/tb_stencil_3x3_sharpen_sobel.sv
